@@ rtl/core/ibrt_pkg.sv @@
// Package for the IP block rule table: request/response/rule types, codes,
// and address key and prefix mask helpers. No dependencies.
package ibrt_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int ADDR_W        = 128;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    localparam logic [1:0] CMD_ADD_ADDR   = 2'd0;
    localparam logic [1:0] CMD_ADD_RANGE  = 2'd1;
    localparam logic [1:0] CMD_ADD_SUBNET = 2'd2;
    localparam logic [1:0] CMD_CHECK      = 2'd3;

    localparam logic [1:0] KIND_ADDR   = 2'd0;
    localparam logic [1:0] KIND_RANGE  = 2'd1;
    localparam logic [1:0] KIND_SUBNET = 2'd2;

    localparam logic FAM_V4 = 1'b0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE_BAD = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        family;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] end_hi;
        logic [63:0] end_lo;
        logic [7:0]  prefix_len;
    } req_t;

    typedef struct packed {
        logic       blocked;
        logic [1:0] status;
    } resp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        family;
        logic [63:0] start_hi;
        logic [63:0] start_lo;
        logic [63:0] end_hi;
        logic [63:0] end_lo;
        logic [7:0]  prefix;
    } rule_t;

    // Comparable key: IPv4 keeps only bits 63:32 of the high half.
    function automatic logic [ADDR_W-1:0] addr_key(input logic fam, input logic [63:0] hi,
                                                   input logic [63:0] lo);
        logic [ADDR_W-1:0] k;
        if (fam == FAM_V4) begin
            k = {hi[63:32], 96'd0};
        end else begin
            k = {hi, lo};
        end
        return k;
    endfunction

    // Prefix is already clamped to at most 128.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [7:0] p);
        logic [ADDR_W-1:0] m;
        if (p == 8'd0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (V6_MAX_PREFIX - p);
        end
        return m;
    endfunction

    function automatic logic [7:0] clamp_prefix(input logic fam, input logic [7:0] p);
        logic [7:0] maxp;
        maxp = (fam == FAM_V4) ? V4_MAX_PREFIX : V6_MAX_PREFIX;
        return (p > maxp) ? maxp : p;
    endfunction

endpackage

@@ rtl/core/ibrt_match.sv @@
// Match unit for one stored rule against the queried address.
// Depends on ibrt_pkg.
module ibrt_match (
    input  logic           q_family,
    input  logic [63:0]    q_hi,
    input  logic [63:0]    q_lo,
    input  ibrt_pkg::rule_t entry,
    output logic           hit
);

    logic [ibrt_pkg::ADDR_W-1:0] q_key;
    logic [ibrt_pkg::ADDR_W-1:0] s_key;
    logic [ibrt_pkg::ADDR_W-1:0] e_key;
    logic [ibrt_pkg::ADDR_W-1:0] mask;
    logic                        kind_hit;

    assign q_key = ibrt_pkg::addr_key(q_family, q_hi, q_lo);
    assign s_key = ibrt_pkg::addr_key(q_family, entry.start_hi, entry.start_lo);
    assign e_key = ibrt_pkg::addr_key(q_family, entry.end_hi, entry.end_lo);
    assign mask  = ibrt_pkg::prefix_mask(entry.prefix);

    always_comb begin
        case (entry.kind)
            ibrt_pkg::KIND_ADDR:   kind_hit = (q_key == s_key);
            ibrt_pkg::KIND_RANGE:  kind_hit = (q_key >= s_key) && (q_key <= e_key);
            ibrt_pkg::KIND_SUBNET: kind_hit = (((q_key ^ s_key) & mask) == '0);
            default:               kind_hit = 1'b0;
        endcase
    end

    assign hit = (entry.family == q_family) && kind_hit;

endmodule

@@ rtl/core/ip_block_rule_table.sv @@
// IP block rule table, top level. Depends on ibrt_pkg and ibrt_match.
// Steps: an add passes through S_ADD and then S_OUT; a check reads the stored rules in order
// in S_SCAN and moves to S_OUT on the first match or once every stored rule has been read.
// Throughput: one request at a time, one rule read per cycle in a scan; the next request is
// taken in the cycle after the response loads.
// Reset (synchronous, aresetn low) empties the table; rule memory is not cleared.
module ip_block_rule_table #(
    parameter int MAX_RULES = ibrt_pkg::MAX_RULES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ibrt_pkg::req_t  s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output ibrt_pkg::resp_t m_resp
);

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    ibrt_pkg::req_t      q_reg, q_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                rvld_reg, rvld_next;
    ibrt_pkg::resp_t     res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    ibrt_pkg::resp_t     m_resp_reg, m_resp_next;

    ibrt_pkg::rule_t     mem [MAX_RULES];
    ibrt_pkg::rule_t     rdata_reg;
    ibrt_pkg::rule_t     wr_entry;
    logic                wr_en;
    logic                full;
    logic                range_bad;
    logic                issue;
    logic                hit;

    assign full = (count_reg == CNT_W'(MAX_RULES));
    assign range_bad = (q_reg.cmd == ibrt_pkg::CMD_ADD_RANGE) &&
        (ibrt_pkg::addr_key(q_reg.family, q_reg.addr_hi, q_reg.addr_lo) >
         ibrt_pkg::addr_key(q_reg.family, q_reg.end_hi, q_reg.end_lo));
    assign wr_en = (state_reg == S_ADD) && !range_bad && !full;
    assign issue = (state_reg == S_SCAN) && (rd_cnt_reg < count_reg);

    always_comb begin
        wr_entry.family   = q_reg.family;
        wr_entry.start_hi = q_reg.addr_hi;
        wr_entry.start_lo = q_reg.addr_lo;
        wr_entry.prefix   = 8'd0;
        case (q_reg.cmd)
            ibrt_pkg::CMD_ADD_ADDR: begin
                wr_entry.kind   = ibrt_pkg::KIND_ADDR;
                wr_entry.end_hi = q_reg.addr_hi;
                wr_entry.end_lo = q_reg.addr_lo;
            end
            ibrt_pkg::CMD_ADD_RANGE: begin
                wr_entry.kind   = ibrt_pkg::KIND_RANGE;
                wr_entry.end_hi = q_reg.end_hi;
                wr_entry.end_lo = q_reg.end_lo;
            end
            default: begin
                wr_entry.kind   = ibrt_pkg::KIND_SUBNET;
                wr_entry.end_hi = 64'd0;
                wr_entry.end_lo = 64'd0;
                wr_entry.prefix = ibrt_pkg::clamp_prefix(q_reg.family, q_reg.prefix_len);
            end
        endcase
    end

    // Requests are handled one at a time, so a write never overlaps a scan read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        rdata_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
    end

    ibrt_match u_match (
        .q_family (q_reg.family),
        .q_hi     (q_reg.addr_hi),
        .q_lo     (q_reg.addr_lo),
        .entry    (rdata_reg),
        .hit      (hit)
    );

    always_comb begin
        state_next   = state_reg;
        q_next       = q_reg;
        count_next   = count_reg;
        rd_cnt_next  = rd_cnt_reg;
        rvld_next    = 1'b0;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_resp_next  = m_resp_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    q_next      = s_req;
                    rd_cnt_next = '0;
                    state_next  = (s_req.cmd == ibrt_pkg::CMD_CHECK) ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                res_next.blocked = 1'b0;
                if (range_bad) begin
                    res_next.status = ibrt_pkg::ST_RANGE_BAD;
                end else if (full) begin
                    res_next.status = ibrt_pkg::ST_FULL;
                end else begin
                    res_next.status = ibrt_pkg::ST_OK;
                    count_next      = count_reg + CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_SCAN: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    rvld_next   = 1'b1;
                end
                // rules come back in order, so the first hit seen is the first match
                if (rvld_reg && hit) begin
                    res_next.blocked = 1'b1;
                    res_next.status  = ibrt_pkg::ST_OK;
                    state_next       = S_OUT;
                end else if (!issue && !rvld_reg) begin
                    res_next.blocked = 1'b0;
                    res_next.status  = ibrt_pkg::ST_OK;
                    state_next       = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_resp_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_cnt_reg  <= '0;
            rvld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            rvld_reg    <= rvld_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg      <= q_next;
        res_reg    <= res_next;
        m_resp_reg <= m_resp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("rule count beyond table size");

    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < CNT_W'(MAX_RULES)))
        else $error("rule write into full table");

    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("rule count did not follow write");

    a_scan_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rvld_reg |-> (rd_cnt_reg <= count_reg) && (rd_cnt_reg != '0))
        else $error("scan read outside stored rules");

    a_resp_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("response issued outside output state");
`endif

endmodule
